// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers shared by the rtl
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/grgp_pkg.sv =====
// grgp_pkg: types, constants and elaboration-time table builders for the
// gamma rgb to grey pipeline; no dependencies
package grgp_pkg;

    localparam int BYTE_W        = 8;
    localparam int BYTE_MAX      = 255;
    localparam int GREY_LEVELS   = 256;
    localparam int SEARCH_STAGES = BYTE_W;
    localparam int ENC_MAX_W     = 24;
    localparam int IDX_MAX_W     = 16;
    // gamma 2.2 written as the ratio 11 / 5
    localparam int GAMMA_NUM     = 11;
    localparam int GAMMA_DEN     = 5;
    // 2^GAMMA_DEN, from rounding at half a step on the grey scale
    localparam int HALF_SCALE    = 32;
    localparam int BIG_W         = 320;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [BIG_W-1:0]  big_t;

    function automatic big_t big_pow(input big_t base, input int n);
        big_t acc;
        acc = big_t'(1);
        for (int i = 0; i < n; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // round(M * (c/255)^(1/2.2)), M = 2^enc_bits - 1, exact integer search:
    // largest r with (2r-1)^11 * 255^5 <= c^5 * (2M)^11
    function automatic logic [ENC_MAX_W-1:0] gamma_encode(input int c, input int enc_bits);
        big_t    rhs;
        big_t    lhs;
        longint  lo;
        longint  hi;
        longint  mid;
        longint  m;
        m   = (longint'(1) << enc_bits) - 1;
        rhs = big_pow(big_t'(c), GAMMA_DEN) * big_pow(big_t'(2 * m), GAMMA_NUM);
        lo  = 0;
        hi  = m;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            lhs = big_pow(big_t'(2 * mid - 1), GAMMA_NUM) * big_pow(big_t'(BYTE_MAX), GAMMA_DEN);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return ENC_MAX_W'(lo);
    endfunction

    // smallest index k whose decoded grey round(255 * (k/K)^2.2) reaches g,
    // K = 2^idx_bits - 1; the level zero starts at index zero
    function automatic logic [IDX_MAX_W-1:0] decode_threshold(input int g, input int idx_bits);
        big_t    lhs;
        big_t    scale;
        longint  lo;
        longint  hi;
        longint  mid;
        longint  kmax;
        kmax  = (longint'(1) << idx_bits) - 1;
        scale = big_t'(HALF_SCALE) * big_pow(big_t'(BYTE_MAX), GAMMA_DEN);
        lhs   = big_pow(big_t'(2 * g - 1), GAMMA_DEN) * big_pow(big_t'(kmax), GAMMA_NUM);
        lo    = 0;
        hi    = (g == 0) ? 0 : kmax;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (lhs <= scale * big_pow(big_t'(mid), GAMMA_NUM)) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return IDX_MAX_W'(lo);
    endfunction

endpackage

// ===== hw/rtl/grgp_search.sv =====
// grgp_search: pipelined binary search of the decode thresholds, one grey bit
// per stage, msb first; depends on grgp_pkg
module grgp_search #(
    parameter int IDX_W = 12
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [IDX_W-1:0] in_idx,
    input  grgp_pkg::byte_t in_alpha,
    output logic            out_valid,
    input  logic            out_ready,
    output grgp_pkg::byte_t out_grey,
    output grgp_pkg::byte_t out_alpha
);
    import grgp_pkg::*;

    localparam int N = SEARCH_STAGES;

    logic [IDX_W-1:0] thr_rom [GREY_LEVELS];

    for (genvar gi = 0; gi < GREY_LEVELS; gi++) begin : g_thr_rom
        localparam logic [IDX_W-1:0] THR_VAL = IDX_W'(decode_threshold(gi, IDX_W));
        assign thr_rom[gi] = THR_VAL;
    end

    logic             valid_reg [N];
    logic [IDX_W-1:0] idx_reg   [N];
    byte_t            grey_reg  [N];
    byte_t            grey_next [N];
    byte_t            alpha_reg [N];
    logic [N-1:0]     adv;

    logic             src_valid [N];
    logic [IDX_W-1:0] src_idx   [N];
    byte_t            src_grey  [N];
    byte_t            src_alpha [N];

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        adv[N-1] = !valid_reg[N-1] || out_ready;
        for (int j = N - 2; j >= 0; j--) begin
            adv[j] = !valid_reg[j] || adv[j+1];
        end
    end

    assign src_valid[0] = in_valid;
    assign src_idx[0]   = in_idx;
    assign src_grey[0]  = '0;
    assign src_alpha[0] = in_alpha;

    for (genvar j = 1; j < N; j++) begin : g_link
        assign src_valid[j] = valid_reg[j-1];
        assign src_idx[j]   = idx_reg[j-1];
        assign src_grey[j]  = grey_reg[j-1];
        assign src_alpha[j] = alpha_reg[j-1];
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam byte_t STEP_BIT = byte_t'(1 << (N - 1 - j));
        byte_t cand;

        assign cand         = src_grey[j] | STEP_BIT;
        assign grey_next[j] = (thr_rom[cand] <= src_idx[j]) ? cand : src_grey[j];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (adv[j]) begin
                valid_reg[j] <= src_valid[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j]) begin
                idx_reg[j]   <= src_idx[j];
                grey_reg[j]  <= grey_next[j];
                alpha_reg[j] <= src_alpha[j];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[N-1];
    assign out_grey  = grey_reg[N-1];
    assign out_alpha = alpha_reg[N-1];

endmodule

// ===== hw/rtl/gamma_rgb_to_grey_pixel.sv =====
// gamma_rgb_to_grey_pixel: top level of the gamma corrected rgba to grey pipe
// depends on grgp_pkg, grgp_search and assert_macros.svh
//
// usage
// - s_axis carries one rgba pixel per transfer; m_axis returns one grey
//   pixel per input transfer, in order, alpha copied through unchanged
// - each colour byte is gamma encoded through a 256 entry table, the three
//   codes are summed and divided by three with a reciprocal multiply, and the
//   top index bits of the quotient are decoded back to a byte by an 8 stage
//   binary search over the 255 grey level thresholds
// - from an s_axis transfer to m_axis_tvalid a pixel passes encode, sum and
//   divide, one register stage each, then the eight search stages
// - throughput is one pixel per cycle while m_axis is not stalled, set by the
//   stage pipeline; there is no iterative unit and no memory
// - every stage has its own valid bit and moves when the next stage is empty
//   or moving, so bubbles close up and new pixels are taken while a finished
//   result waits on m_axis; s_axis_tready drops only when all 11 stages hold
//   a pixel and m_axis is stalled
// - a stalled m_axis holds its data; nothing is dropped or repeated
// - reset (aresetn low at a clock edge) empties the pipe; the tables are
//   constants, so the block is ready in the first cycle after reset
`include "assert_macros.svh"

module gamma_rgb_to_grey_pixel #(
    parameter int ENCODED_BITS      = 16,
    parameter int DECODE_INDEX_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // grey [7:0], alpha_out [15:8]
);
    import grgp_pkg::*;

    localparam int ENC_W       = ENCODED_BITS;
    localparam int IDX_W       = DECODE_INDEX_BITS;
    localparam int STAGES      = 3;
    localparam int DIVISOR     = 3;
    // sum of three codes stays below 3 * 2^ENC_W
    localparam int SUM_W       = ENC_W + 2;
    // floor(x/3) == (x * RECIP) >> RECIP_SHIFT for every x below 2^SUM_W
    localparam int RECIP_SHIFT = SUM_W + 1;
    localparam int PROD_W      = 2 * SUM_W;
    localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3;
    localparam int CHECK_W     = SUM_W + 2;

    // gamma encode table, filled at elaboration
    logic [ENC_W-1:0] enc_rom [GREY_LEVELS];

    for (genvar gi = 0; gi < GREY_LEVELS; gi++) begin : g_enc_rom
        localparam logic [ENC_W-1:0] ENC_VAL = ENC_W'(gamma_encode(gi, ENCODED_BITS));
        assign enc_rom[gi] = ENC_VAL;
    end

    // pipe control
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;
    logic              srch_ready;

    // stage payload
    logic [ENC_W-1:0]  enc_r_reg, enc_r_next;
    logic [ENC_W-1:0]  enc_g_reg, enc_g_next;
    logic [ENC_W-1:0]  enc_b_reg, enc_b_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [ENC_W-1:0]  quot_reg, quot_next;
    byte_t             alpha_reg  [STAGES];
    byte_t             alpha_next [STAGES];
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  idx;
    byte_t             grey;
    byte_t             alpha_out;

    // a stage advances when empty or when the stage after it advances
    assign adv[2] = !valid_reg[2] || srch_ready;
    assign adv[1] = !valid_reg[1] || adv[2];
    assign adv[0] = !valid_reg[0] || adv[1];

    assign s_axis_tready = adv[0];
    assign valid_next    = {valid_reg[1], valid_reg[0], s_axis_tvalid};

    // stage 0: three table reads
    assign enc_r_next    = enc_rom[s_axis_tdata[7:0]];
    assign enc_g_next    = enc_rom[s_axis_tdata[15:8]];
    assign enc_b_next    = enc_rom[s_axis_tdata[23:16]];
    assign alpha_next[0] = s_axis_tdata[31:24];

    // stage 1: sum of the codes
    assign sum_next      = SUM_W'(enc_r_reg) + SUM_W'(enc_g_reg) + SUM_W'(enc_b_reg);
    assign alpha_next[1] = alpha_reg[0];

    // stage 2: truncating divide by three
    assign prod          = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign quot_next     = prod[RECIP_SHIFT +: ENC_W];
    assign alpha_next[2] = alpha_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            enc_r_reg    <= enc_r_next;
            enc_g_reg    <= enc_g_next;
            enc_b_reg    <= enc_b_next;
            alpha_reg[0] <= alpha_next[0];
        end
        if (adv[1]) begin
            sum_reg      <= sum_next;
            alpha_reg[1] <= alpha_next[1];
        end
        if (adv[2]) begin
            quot_reg     <= quot_next;
            alpha_reg[2] <= alpha_next[2];
        end
    end

    // decode index: top bits of the quotient, or the quotient moved up when
    // the index is wider than the code
    if (IDX_W <= ENC_W) begin : g_idx_narrow
        assign idx = quot_reg[ENC_W-1 -: IDX_W];
    end else begin : g_idx_wide
        assign idx = {quot_reg, {(IDX_W - ENC_W){1'b0}}};
    end

    grgp_search #(
        .IDX_W (IDX_W)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_reg[2]),
        .in_ready  (srch_ready),
        .in_idx    (idx),
        .in_alpha  (alpha_reg[2]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_grey  (grey),
        .out_alpha (alpha_out)
    );

    assign m_axis_tdata = {alpha_out, grey};

    // an empty output stage never holds back the input side
    `ASSERT_IMPLIES(a_ready_when_out_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready, "input stalled while output stage is empty")
    // input backpressure only when the output is stalled
    `ASSERT_IMPLIES(a_stall_from_output, aclk, aresetn, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without an output stall")
    // the reciprocal multiply gives the exact truncated quotient
    `ASSERT_NEXT(a_div3_exact, aclk, aresetn, adv[2] && valid_reg[1], (CHECK_W'(quot_reg) * CHECK_W'(DIVISOR) <= CHECK_W'($past(sum_reg))) && (CHECK_W'($past(sum_reg)) - CHECK_W'(quot_reg) * CHECK_W'(DIVISOR) < CHECK_W'(DIVISOR)), "divide by three is off")

endmodule

// ===== tb/gamma_rgb_to_grey_pixel_test.sv =====
// gamma_rgb_to_grey_pixel_test: self-checking bench for the rgba to grey pipe
// needs grgp_pkg and gamma_rgb_to_grey_pixel; gamma tables are rebuilt here
// with exact wide-integer comparisons and every m_axis transfer is checked
`timescale 1ns / 100ps

module gamma_rgb_to_grey_pixel_test;

    import grgp_pkg::*;

    // widths of the gamma code and of the decode index, as built into uut
    localparam int ENC_BITS    = 16;
    localparam int IDX_BITS    = 12;
    localparam int ENC_MAX     = (1 << ENC_BITS) - 1;
    localparam int IDX_MAX     = (1 << IDX_BITS) - 1;
    // gamma 2.2 as the exponent ratio 11 / 5
    localparam int EXP_NUM     = 11;
    localparam int EXP_DEN     = 5;
    // 2^5: the half-step rounding of the grey byte raised to the fifth power
    localparam int HALF_POW    = 32;
    localparam int PIPE_DEPTH  = 11;
    localparam int DRAIN_WAIT  = 2 * PIPE_DEPTH + 4;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 400;

    typedef logic [255:0] wide_t;

    // packed msb first: alpha_out in the upper byte, grey in the lower
    typedef struct packed {
        byte_t alpha_out;
        byte_t grey;
    } grey_pixel_t;

    // clock, reset and the stream ports; the ones the bench drives are known from time zero
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // grey [7:0], alpha_out [15:8]

    // gamma code per color byte and grey byte per decode index
    logic [ENC_BITS-1:0] encode_lut [256];
    byte_t               decode_lut [IDX_MAX+1];

    // grey pixels still owed by uut, oldest first
    grey_pixel_t grey_expected [$];

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int fail_count = 0;
    int stall_cycles = 0;

    gamma_rgb_to_grey_pixel #(
        .ENCODED_BITS      (ENC_BITS),
        .DECODE_INDEX_BITS (IDX_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic wide_t wide_power(input wide_t base, input int n);
        wide_t acc;
        acc = wide_t'(1);
        repeat (n) acc = acc * base;
        return acc;
    endfunction

    // encode: largest r with (2r-1)^11 * 255^5 <= c^5 * (2M)^11
    // decode: largest g with (2g-1)^5 * K^11 <= 32 * 255^5 * k^11
    // both tables are monotonic, so each search starts where the last one ended
    task automatic build_gamma_tables();
        wide_t two_m_pow;
        wide_t byte_pow;
        wide_t idx_pow;
        wide_t target;
        wide_t trial;
        wide_t level_floor [256];
        int    lo;
        int    hi;
        int    mid;
        int    level;
        two_m_pow = wide_power(wide_t'(2 * ENC_MAX), EXP_NUM);
        byte_pow  = wide_power(wide_t'(255), EXP_DEN);
        idx_pow   = wide_power(wide_t'(IDX_MAX), EXP_NUM);
        lo = 0;
        for (int c = 0; c < 256; c++) begin
            target = wide_power(wide_t'(c), EXP_DEN) * two_m_pow;
            hi = ENC_MAX;
            while (lo < hi) begin
                mid   = lo + (hi - lo + 1) / 2;
                trial = wide_power(wide_t'(2 * mid - 1), EXP_NUM) * byte_pow;
                if (trial <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            encode_lut[c] = lo[ENC_BITS-1:0];
        end
        // threshold that the scaled index must reach for each grey level
        for (int g = 1; g < 256; g++) begin
            level_floor[g] = wide_power(wide_t'(2 * g - 1), EXP_DEN) * idx_pow;
        end
        level = 0;
        for (int k = 0; k <= IDX_MAX; k++) begin
            target = wide_t'(HALF_POW) * byte_pow * wide_power(wide_t'(k), EXP_NUM);
            while (level < 255 && level_floor[level + 1] <= target) level++;
            decode_lut[k] = byte_t'(level);
        end
    endtask

    // mean of the three gamma codes, truncated, top index bits decoded
    function automatic grey_pixel_t predict_grey_pixel(input byte_t red, input byte_t green,
                                                       input byte_t blue, input byte_t alpha);
        logic [ENC_BITS+1:0] code_sum;
        logic [ENC_BITS+1:0] mean_code;
        grey_pixel_t         pix;
        code_sum      = (ENC_BITS+2)'(encode_lut[red]) + (ENC_BITS+2)'(encode_lut[green])
                      + (ENC_BITS+2)'(encode_lut[blue]);
        mean_code     = (ENC_BITS+2)'(code_sum / 3);
        pix.grey      = decode_lut[mean_code[ENC_BITS-1 -: IDX_BITS]];
        pix.alpha_out = alpha;
        return pix;
    endfunction

    // one s_axis transfer; called at a rising edge, returns at the accepting edge
    // valid stays high into the next call unless that call opens a gap
    task automatic send_pixel(input byte_t red, input byte_t green,
                              input byte_t blue, input byte_t alpha);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {alpha, blue, green, red};
        do @(posedge aclk); while (!s_axis_tready);
        grey_expected.push_back(predict_grey_pixel(red, green, blue, alpha));
    endtask

    // black, white, single channels, pairs and the truncating small sums
    task automatic test_channel_extremes();
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0,   8'h55);
        send_pixel(8'd0,   8'd255, 8'd0,   8'hAA);
        send_pixel(8'd0,   8'd0,   8'd255, 8'h01);
        send_pixel(8'd255, 8'd255, 8'd0,   8'h80);
        send_pixel(8'd0,   8'd255, 8'd255, 8'h7F);
        send_pixel(8'd255, 8'd0,   8'd255, 8'hFE);
        send_pixel(8'd1,   8'd0,   8'd0,   8'h00);
        send_pixel(8'd0,   8'd0,   8'd1,   8'hFF);
        send_pixel(8'd1,   8'd1,   8'd1,   8'h0F);
        send_pixel(8'd254, 8'd254, 8'd254, 8'hF0);
        send_pixel(8'd254, 8'd255, 8'd255, 8'h3C);
    endtask

    // equal channels should come back close to the same level
    task automatic test_equal_channel_levels();
        byte_t levels [8];
        levels = '{8'd2, 8'd16, 8'd64, 8'd127, 8'd128, 8'd191, 8'd240, 8'd253};
        foreach (levels[i]) send_pixel(levels[i], levels[i], levels[i], ~levels[i]);
    endtask

    function automatic byte_t edge_byte();
        byte_t picks [6];
        picks = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        return picks[$urandom_range(5)];
    endfunction

    // mostly uniform pixels, with grey, edge-valued and single-channel ones mixed in
    task automatic test_random_pixels(input int count);
        byte_t r;
        byte_t g;
        byte_t b;
        byte_t a;
        int    kind;
        repeat (count) begin
            kind = $urandom_range(9);
            a    = byte_t'($urandom);
            if (kind <= 5) begin
                r = byte_t'($urandom);
                g = byte_t'($urandom);
                b = byte_t'($urandom);
            end else if (kind <= 7) begin
                r = byte_t'($urandom);
                g = r;
                b = r;
            end else if (kind == 8) begin
                r = edge_byte();
                g = edge_byte();
                b = edge_byte();
            end else begin
                r = '0;
                g = '0;
                b = '0;
                case ($urandom_range(2))
                    0: r = byte_t'($urandom);
                    1: g = byte_t'($urandom);
                    default: b = byte_t'($urandom);
                endcase
            end
            send_pixel(r, g, b, a);
        end
    endtask

    // receiver side: random stalls on m_axis
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // every m_axis transfer is matched against the oldest owed pixel
    always @(posedge aclk) begin : result_check
        grey_pixel_t want;
        grey_pixel_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (grey_expected.size() == 0) begin
                $error("transfer with nothing owed: grey %0d alpha_out %0d",
                       got.grey, got.alpha_out);
                fail_count++;
            end else begin
                want = grey_expected.pop_front();
                if (got.grey !== want.grey) begin
                    $error("grey: expected %0d, actual %0d", want.grey, got.grey);
                    fail_count++;
                end
                if (got.alpha_out !== want.alpha_out) begin
                    $error("alpha_out: expected %0d, actual %0d", want.alpha_out, got.alpha_out);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        build_gamma_tables();

        // reset held low at the start, then released
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles a little, receiver half the time
        src_idle_pct  = 19;
        sink_idle_pct = 50;
        test_channel_extremes();
        test_equal_channel_levels();
        test_random_pixels(PHASE_ITEMS);

        // sender idles half the time, receiver a little
        src_idle_pct  = 50;
        sink_idle_pct = 19;
        test_random_pixels(PHASE_ITEMS);

        // back to back at full rate
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_pixels(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;

        // drain, then give the pipe time to show any stray transfer
        while (grey_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/grgp_pkg.sv
hw/rtl/grgp_search.sv
hw/rtl/gamma_rgb_to_grey_pixel.sv
tb/gamma_rgb_to_grey_pixel_test.sv
